// File: rtl/tlgs_pkg.sv
// ----------------------------------------------------------------------------
// tlgs_pkg
// Shared constants, codes and types for the toroidal Life grid stepper.
// ----------------------------------------------------------------------------
package tlgs_pkg;

    localparam int MAX_SIDE = 64;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * COORD_W + 1;
    localparam int DEPTH    = 2 ** ADDR_W;
    localparam int SIDE_W   = 7;
    localparam int GEN_W    = 16;
    localparam int CNT_W    = 4;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic CFG_SIDE  = 1'b0;
    localparam logic CFG_ORDER = 1'b1;

    localparam logic [CNT_W-1:0] LIVE_LO = CNT_W'(2);
    localparam logic [CNT_W-1:0] LIVE_HI = CNT_W'(3);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic clr;
        logic add;
    } acc_ctl_t;

endpackage

// File: rtl/tlgs_grid_mem.sv
// ----------------------------------------------------------------------------
// tlgs_grid_mem
// Both cell buffers in one memory: bank bit, row, column. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module tlgs_grid_mem
(
    input  logic              clk,
    input  tlgs_pkg::mem_req_t req,
    output logic              rdata
);

    logic mem [tlgs_pkg::DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tlgs_count.sv
// ----------------------------------------------------------------------------
// tlgs_count
// Shared neighbor counter: sums one fetched neighbor bit per cycle and applies
// the survival rule to the final sum.
// ----------------------------------------------------------------------------
module tlgs_count
(
    input  logic               clk,
    input  logic               rst_n,
    input  tlgs_pkg::acc_ctl_t ctl,
    input  logic               nbr_bit,
    output logic               alive_next
);

    logic [tlgs_pkg::CNT_W-1:0] count_reg;
    logic [tlgs_pkg::CNT_W-1:0] count_next;
    logic [tlgs_pkg::CNT_W-1:0] total;

    assign total      = count_reg + {{(tlgs_pkg::CNT_W-1){1'b0}}, nbr_bit};
    assign alive_next = (total == tlgs_pkg::LIVE_LO) || (total == tlgs_pkg::LIVE_HI);

    always_comb
    begin
        priority if (ctl.clr)
        begin
            count_next = '0;
        end
        else if (ctl.add)
        begin
            count_next = total;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/tlgs_ctrl.sv
// ----------------------------------------------------------------------------
// tlgs_ctrl
// Item sequencer: serves loads and reads, and walks every cell of every
// generation, fetching eight neighbors then writing the new cell.
// ----------------------------------------------------------------------------
module tlgs_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   mode,
    input  logic [tlgs_pkg::COORD_W-1:0] row,
    input  logic [tlgs_pkg::COORD_W-1:0] col,
    input  logic                         alive_in,
    input  logic [tlgs_pkg::GEN_W-1:0]   generations,
    input  logic [tlgs_pkg::COORD_W-1:0] last,
    input  logic                         order,
    input  logic                         rdata,
    input  logic                         alive_next,
    output tlgs_pkg::mem_req_t           mem_req,
    output tlgs_pkg::acc_ctl_t           acc_ctl,
    output logic                         busy,
    output logic                         result_strobe,
    output logic                         alive_out,
    output logic                         done_res
);

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_WRITE} state_t;

    localparam int CW = tlgs_pkg::COORD_W;

    state_t                     state_reg;
    logic [2:0]                 k_reg;
    logic [CW-1:0]              r_reg;
    logic [CW-1:0]              c_reg;
    logic [CW-1:0]              last_reg;
    logic                       order_reg;
    logic                       active_reg;
    logic [tlgs_pkg::GEN_W-1:0] gens_reg;
    logic                       rd_pend_reg;
    logic                       rd_in_reg;
    logic                       done_reg;

    logic          accept;
    logic          in_grid;
    logic [CW-1:0] up;
    logic [CW-1:0] dn;
    logic [CW-1:0] lf;
    logic [CW-1:0] rt;
    logic [CW-1:0] nr;
    logic [CW-1:0] nc;
    logic          wbank;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign in_grid = (row <= last) && (col <= last);

    // wrap at the torus edges
    assign up = (r_reg == '0) ? last_reg : r_reg - CW'(1);
    assign dn = (r_reg == last_reg) ? '0 : r_reg + CW'(1);
    assign lf = (c_reg == '0) ? last_reg : c_reg - CW'(1);
    assign rt = (c_reg == last_reg) ? '0 : c_reg + CW'(1);

    always_comb
    begin
        unique case (k_reg)
            3'd0:    begin nr = up;    nc = lf;    end
            3'd1:    begin nr = up;    nc = c_reg; end
            3'd2:    begin nr = up;    nc = rt;    end
            3'd3:    begin nr = r_reg; nc = lf;    end
            3'd4:    begin nr = r_reg; nc = rt;    end
            3'd5:    begin nr = dn;    nc = lf;    end
            3'd6:    begin nr = dn;    nc = c_reg; end
            default: begin nr = dn;    nc = rt;    end
        endcase
    end

    // in-place order writes the buffer it reads
    assign wbank = order_reg ? active_reg : !active_reg;

    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_req.raddr = {active_reg, row, col};
                mem_req.waddr = {active_reg, row, col};
                mem_req.wdata = alive_in;
                mem_req.we    = accept && (mode == tlgs_pkg::MODE_LOAD) && in_grid;
            end
            S_FETCH:
            begin
                mem_req.raddr = {active_reg, nr, nc};
            end
            default:
            begin
                mem_req.raddr = {active_reg, nr, nc};
                mem_req.waddr = {wbank, r_reg, c_reg};
                mem_req.wdata = alive_next;
                mem_req.we    = 1'b1;
            end
        endcase
    end

    // neighbor k arrives in the cycle after its fetch
    assign acc_ctl.clr = (state_reg == S_FETCH) && (k_reg == 3'd0);
    assign acc_ctl.add = (state_reg == S_FETCH) && (k_reg != 3'd0);

    assign result_strobe = rd_pend_reg || done_reg;
    assign alive_out     = rd_pend_reg && rd_in_reg && rdata;
    assign done_res      = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            last_reg    <= '0;
            order_reg   <= 1'b0;
            active_reg  <= 1'b0;
            gens_reg    <= '0;
            rd_pend_reg <= 1'b0;
            rd_in_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rd_pend_reg <= (mode == tlgs_pkg::MODE_READ);
                        rd_in_reg   <= in_grid;
                        if (mode == tlgs_pkg::MODE_RUN)
                        begin
                            if (generations == '0)
                            begin
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                gens_reg  <= generations;
                                last_reg  <= last;
                                order_reg <= order;
                                r_reg     <= '0;
                                c_reg     <= '0;
                                k_reg     <= '0;
                                state_reg <= S_FETCH;
                            end
                        end
                    end
                end
                S_FETCH:
                begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd7)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                default:
                begin
                    k_reg     <= '0;
                    state_reg <= S_FETCH;
                    if (c_reg != last_reg)
                    begin
                        c_reg <= c_reg + CW'(1);
                    end
                    else
                    begin
                        c_reg <= '0;
                        if (r_reg != last_reg)
                        begin
                            r_reg <= r_reg + CW'(1);
                        end
                        else
                        begin
                            // generation complete: swap buffers in synchronous order
                            r_reg <= '0;
                            if (!order_reg)
                            begin
                                active_reg <= !active_reg;
                            end
                            gens_reg <= gens_reg - tlgs_pkg::GEN_W'(1);
                            if (gens_reg == tlgs_pkg::GEN_W'(1))
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !mem_req.we)
        else $error("grid written during neighbor fetch");

    a_write_after_eight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> $past(state_reg == S_FETCH && k_reg == 3'd7))
        else $error("cell written before all neighbors fetched");

    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (r_reg <= last_reg && c_reg <= last_reg))
        else $error("walk left the grid");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_pend_reg && done_reg))
        else $error("read and run results collide");
`endif

endmodule

// File: rtl/toroidal_life_grid_step.sv
// ----------------------------------------------------------------------------
// toroidal_life_grid_step
// Square wraparound Life grid: load, read and multi-generation run items.
// ----------------------------------------------------------------------------
// A load takes effect at its accept edge and busy stays low. A read returns
// its cell on result_strobe in the cycle right after the accept. A run holds
// busy while it walks every cell of every generation and then pulses
// result_strobe with done_res high; a run of zero generations pulses it in
// the next cycle. Each cell costs eight neighbor fetches through the single
// grid read port plus one write. Results cannot be held off: capture
// them on the strobe cycle. Write configuration only while busy is low.
module toroidal_life_grid_step
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    mode,
    input  logic [tlgs_pkg::COORD_W-1:0]  row,
    input  logic [tlgs_pkg::COORD_W-1:0]  col,
    input  logic                          alive_in,
    input  logic [tlgs_pkg::GEN_W-1:0]    generations,
    output logic                          result_strobe,
    output logic                          alive_out,
    output logic                          done_res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [tlgs_pkg::SIDE_W-1:0]   cfg_data
);

    localparam int SW = tlgs_pkg::SIDE_W;

    logic [SW-1:0]                side_reg;
    logic                         order_reg;
    logic [tlgs_pkg::COORD_W-1:0] last;
    logic                         rdata;
    logic                         alive_next;
    tlgs_pkg::mem_req_t           mem_req;
    tlgs_pkg::acc_ctl_t           acc_ctl;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= SW'(tlgs_pkg::MAX_SIDE);
            order_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tlgs_pkg::CFG_SIDE:  side_reg  <= cfg_data;
                default:             order_reg <= cfg_data[0];
            endcase
        end
    end

    // clamp side to 3..MAX_SIDE and hold it as the last index
    always_comb
    begin
        priority if (side_reg < SW'(3))
        begin
            last = tlgs_pkg::COORD_W'(2);
        end
        else if (side_reg > SW'(tlgs_pkg::MAX_SIDE))
        begin
            last = tlgs_pkg::COORD_W'(tlgs_pkg::MAX_SIDE - 1);
        end
        else
        begin
            last = tlgs_pkg::COORD_W'(side_reg - SW'(1));
        end
    end

    tlgs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .mode          (mode),
        .row           (row),
        .col           (col),
        .alive_in      (alive_in),
        .generations   (generations),
        .last          (last),
        .order         (order_reg),
        .rdata         (rdata),
        .alive_next    (alive_next),
        .mem_req       (mem_req),
        .acc_ctl       (acc_ctl),
        .busy          (busy),
        .result_strobe (result_strobe),
        .alive_out     (alive_out),
        .done_res      (done_res)
    );

    tlgs_count u_count
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (acc_ctl),
        .nbr_bit    (rdata),
        .alive_next (alive_next)
    );

    tlgs_grid_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

endmodule
